/* rtl/bpa_pkg.sv */
// shared constants, types and table arithmetic for the bloch phase accumulator
// no dependencies; imported by every rtl module of the block except bpa_ram

package bpa_pkg;

  localparam int ORBITAL_COUNT_DEF   = 256;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int COL_COUNT           = 256;
  localparam int TAB_W               = 15;
  localparam int SUM_W               = 48;
  localparam int INC_W               = 41;
  localparam int APB_ADDR_W          = 4;
  localparam int APB_DATA_W          = 32;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ACCUM = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_K_A = 2'd0;
  localparam logic [1:0] REG_K_B = 2'd1;
  localparam logic [1:0] REG_K_C = 2'd2;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [15:0] k_a;
    logic [15:0] k_b;
    logic [15:0] k_c;
  } k_cfg_t;

  // quarter-wave sine entry, Q30 taylor series to x^17, scaled to Q1.15
  function automatic logic [TAB_W-1:0] bpa_sin_entry(input int unsigned i,
                                                    input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      s;
    logic [63:0] e;
    x    = (HALF_PI_Q30 * 64'(i)) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    s    = s + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    s    = s + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    s    = s + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 64'd272;
    s    = s + longint'(term);
    if (s < 0) begin
      s = 0;
    end
    e = (64'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (e > 64'd32767) begin
      e = 64'd32767;
    end
    return e[TAB_W-1:0];
  endfunction

endpackage

/* rtl/bpa_ram.sv */
// generic single-write, single-read synchronous ram with registered read data
// depends on nothing; used for the k-space sum store

module bpa_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bpa_sin_rom.sv */
// quarter-wave sine rom, two registered read ports for T[i] and T[N-i]
// depends on bpa_pkg for the table entry function

module bpa_sin_rom
  import bpa_pkg::*;
#(
  parameter int ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] idx_i,
  output logic [TAB_W-1:0]     fwd_o,
  output logic [TAB_W-1:0]     rev_o
);

  localparam int N = 1 << ADDR_BITS;

  function automatic logic [(N+1)*TAB_W-1:0] build_tab();
    logic [(N+1)*TAB_W-1:0] t;
    t = '0;
    for (int i = 0; i <= N; i++) begin
      t[i*TAB_W +: TAB_W] = bpa_sin_entry(i, ADDR_BITS);
    end
    return t;
  endfunction

  localparam logic [(N+1)*TAB_W-1:0] TAB = build_tab();

  logic [ADDR_BITS:0]   idx_fwd;
  logic [ADDR_BITS:0]   idx_rev;
  logic [TAB_W-1:0]     fwd_q;
  logic [TAB_W-1:0]     rev_q;

  assign idx_fwd = {1'b0, idx_i};
  assign idx_rev = (ADDR_BITS+1)'(N) - idx_fwd;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      fwd_q <= TAB[idx_fwd * TAB_W +: TAB_W];
      rev_q <= TAB[idx_rev * TAB_W +: TAB_W];
    end
  end

  assign fwd_o = fwd_q;
  assign rev_o = rev_q;

endmodule

/* rtl/bpa_apb_regs.sv */
// apb register bank holding the three reduced k coordinates
// depends on bpa_pkg for register indexes and the k_cfg_t struct

module bpa_apb_regs
  import bpa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output logic [APB_DATA_W-1:0] prdata_o,
  output k_cfg_t                cfg_o
);

  k_cfg_t     cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign reg_idx = paddr_i[3:2];
  assign wr_en   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_K_A: cfg_q.k_a <= pwdata_i[15:0];
        REG_K_B: cfg_q.k_b <= pwdata_i[15:0];
        REG_K_C: cfg_q.k_c <= pwdata_i[15:0];
        default: cfg_q     <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_K_A: prdata_o = {16'b0, cfg_q.k_a};
      REG_K_B: prdata_o = {16'b0, cfg_q.k_b};
      REG_K_C: prdata_o = {16'b0, cfg_q.k_c};
      default: prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/bpa_core.sv */
// read-modify-write engine: phase, table lookup, multiply, saturating add on the sum store
// depends on bpa_pkg, bpa_ram and bpa_sin_rom

module bpa_core
  import bpa_pkg::*;
#(
  parameter int ORBITAL_COUNT   = ORBITAL_COUNT_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  k_cfg_t             cfg_i,
  input  logic               start_i,
  input  logic [1:0]         operation_i,
  input  logic [7:0]         row_i,
  input  logic [7:0]         col_i,
  input  logic signed [31:0] element_i,
  input  logic signed [7:0]  cell_a_i,
  input  logic signed [7:0]  cell_b_i,
  input  logic signed [7:0]  cell_c_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [SUM_W-1:0]   real_sum_o,
  output logic [SUM_W-1:0]   imag_sum_o,
  output logic               saturated_o
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_MUL, S_ADD} state_e;

  localparam int ROW_SLOTS = (ORBITAL_COUNT < COL_COUNT) ? ORBITAL_COUNT : COL_COUNT;
  localparam int DEPTH     = ROW_SLOTS * COL_COUNT;
  localparam int AW        = $clog2(DEPTH);
  localparam int AB        = TABLE_ADDR_BITS;

  function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] a,
                                             input logic [INC_W-1:0] inc);
    logic [SUM_W:0] s;
    logic [SUM_W:0] r;
    s = {a[SUM_W-1], a} + {{(SUM_W+1-INC_W){inc[INC_W-1]}}, inc};
    if (s[SUM_W] != s[SUM_W-1]) begin
      r = {1'b1, s[SUM_W], {(SUM_W-1){~s[SUM_W]}}};
    end else begin
      r = {1'b0, s[SUM_W-1:0]};
    end
    return r;
  endfunction

  state_e             state_q;
  logic [1:0]         op_q;
  logic signed [31:0] elem_q;
  logic [15:0]        phase_q;
  logic [AW-1:0]      addr_q;
  logic               in_range_q;
  logic [1:0]         quad_q;
  logic [SUM_W-1:0]   prod_re_q;
  logic [SUM_W-1:0]   prod_im_q;
  logic [SUM_W-1:0]   real_q;
  logic [SUM_W-1:0]   imag_q;
  logic               sat_q;
  logic               done_q;

  logic               accept;
  logic [15:0]        ph_a;
  logic [15:0]        ph_b;
  logic [15:0]        ph_c;
  logic [15:0]        phase_d;
  logic [15:0]        addr_full;
  logic [AW-1:0]      addr_in;
  logic               in_range_d;

  logic [AB-1:0]      tab_idx;
  logic [TAB_W-1:0]   tab_fwd;
  logic [TAB_W-1:0]   tab_rev;
  logic signed [15:0] t_fwd;
  logic signed [15:0] t_rev;
  logic signed [15:0] sin_v;
  logic signed [15:0] cos_v;
  logic signed [SUM_W-1:0] elem_x;
  logic signed [SUM_W-1:0] prod_re_d;
  logic signed [SUM_W-1:0] prod_im_d;

  logic [SUM_W-1:0]   rnd_re;
  logic [SUM_W-1:0]   rnd_im;
  logic [SUM_W:0]     add_re;
  logic [SUM_W:0]     add_im;
  logic [2*SUM_W-1:0] rdata;
  logic [SUM_W-1:0]   old_re;
  logic [SUM_W-1:0]   old_im;
  logic               mem_we;
  logic [2*SUM_W-1:0] mem_wdata;
  logic [SUM_W-1:0]   res_re;
  logic [SUM_W-1:0]   res_im;
  logic               res_sat;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  // phase as a wrapping fraction of a turn
  assign ph_a    = cfg_i.k_a * {{8{cell_a_i[7]}}, cell_a_i};
  assign ph_b    = cfg_i.k_b * {{8{cell_b_i[7]}}, cell_b_i};
  assign ph_c    = cfg_i.k_c * {{8{cell_c_i[7]}}, cell_c_i};
  assign phase_d = ph_a + ph_b + ph_c;

  assign addr_full  = {row_i, col_i};
  assign addr_in    = addr_full[AW-1:0];
  assign in_range_d = (32'(row_i) < ORBITAL_COUNT) && (32'(col_i) < ORBITAL_COUNT);

  assign tab_idx = phase_q[13 -: AB];

  bpa_sin_rom #(
    .ADDR_BITS(AB)
  ) u_rom (
    .clk_i (clk_i),
    .re_i  (state_q == S_LOOK),
    .idx_i (tab_idx),
    .fwd_o (tab_fwd),
    .rev_o (tab_rev)
  );

  assign t_fwd = $signed({1'b0, tab_fwd});
  assign t_rev = $signed({1'b0, tab_rev});

  always_comb begin
    case (quad_q)
      2'd0: begin
        sin_v = t_fwd;
        cos_v = t_rev;
      end
      2'd1: begin
        sin_v = t_rev;
        cos_v = -t_fwd;
      end
      2'd2: begin
        sin_v = -t_fwd;
        cos_v = -t_rev;
      end
      default: begin
        sin_v = -t_rev;
        cos_v = t_fwd;
      end
    endcase
  end

  assign elem_x    = $signed({{(SUM_W-32){elem_q[31]}}, elem_q});
  assign prod_re_d = elem_x * $signed({{(SUM_W-16){cos_v[15]}}, cos_v});
  assign prod_im_d = elem_x * $signed({{(SUM_W-16){sin_v[15]}}, sin_v});

  bpa_ram #(
    .WIDTH(2*SUM_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (addr_q),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (addr_in),
    .rdata_o (rdata)
  );

  assign old_re = rdata[2*SUM_W-1:SUM_W];
  assign old_im = rdata[SUM_W-1:0];

  // round half up from q9.38 to q16.31
  assign rnd_re = prod_re_q + SUM_W'(64);
  assign rnd_im = prod_im_q + SUM_W'(64);
  assign add_re = sat_add(old_re, rnd_re[SUM_W-1:7]);
  assign add_im = sat_add(old_im, rnd_im[SUM_W-1:7]);

  assign mem_we    = (state_q == S_ADD) && in_range_q &&
                     ((op_q == OP_CLEAR) || (op_q == OP_ACCUM));
  assign mem_wdata = (op_q == OP_ACCUM) ? {add_re[SUM_W-1:0], add_im[SUM_W-1:0]} : '0;

  always_comb begin
    res_re  = '0;
    res_im  = '0;
    res_sat = 1'b0;
    if (in_range_q) begin
      case (op_q)
        OP_CLEAR: begin
          res_re = '0;
          res_im = '0;
        end
        OP_ACCUM: begin
          res_re  = add_re[SUM_W-1:0];
          res_im  = add_im[SUM_W-1:0];
          res_sat = add_re[SUM_W] || add_im[SUM_W];
        end
        default: begin
          res_re = old_re;
          res_im = old_im;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= OP_CLEAR;
      elem_q     <= '0;
      phase_q    <= '0;
      addr_q     <= '0;
      in_range_q <= 1'b0;
      quad_q     <= '0;
      prod_re_q  <= '0;
      prod_im_q  <= '0;
      real_q     <= '0;
      imag_q     <= '0;
      sat_q      <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q       <= operation_i;
            elem_q     <= element_i;
            phase_q    <= phase_d;
            addr_q     <= addr_in;
            in_range_q <= in_range_d;
            state_q    <= S_LOOK;
          end
        end
        S_LOOK: begin
          quad_q  <= phase_q[15:14];
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_re_q <= prod_re_d;
          prod_im_q <= prod_im_d;
          state_q   <= S_ADD;
        end
        S_ADD: begin
          real_q  <= res_re;
          imag_q  <= res_im;
          sat_q   <= res_sat;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o      = done_q;
  assign real_sum_o  = real_q;
  assign imag_sum_o  = imag_q;
  assign saturated_o = sat_q;

  a_done_after_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_ADD))
    else $error("result strobe without a finished transaction");

  a_write_in_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_ADD) && in_range_q)
    else $error("store written outside the write-back step");

  a_sat_only_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && sat_q) |-> (op_q == OP_ACCUM) && in_range_q)
    else $error("saturation flagged on a non-accumulate transaction");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_LOOK) && !done_q)
    else $error("accepted transaction did not enter lookup");

endmodule

/* rtl/bloch_phase_accumulator_top.sv */
// top level of the bloch phase accumulator: apb register bank and accumulate engine
// depends on bpa_pkg, bpa_apb_regs and bpa_core
//
// channel   direction  handshake                       payload
// command   in         start_i high while busy_o low   operation_i row_i col_i element_i cell_*_i
// result    out        done_o strobe, one cycle        real_sum_o imag_sum_o saturated_o
// config    in/out     psel penable pwrite, pready=1   paddr pwdata prdata
//
// busy_o is high from the accepting edge through the lookup, multiply and add states, and
// done_o is high once the engine is back in idle, when a new command may be accepted
// the sequence is the read-modify-write of one entry in the sum ram: read, table lookup,
// multiply, saturating add with write-back
// reset clears the k registers and control; the sum ram is not cleared and entries need a clear
// done_o is high for exactly one cycle; the sums and flag hold until the next result

module bloch_phase_accumulator_top
  import bpa_pkg::*;
#(
  parameter int ORBITAL_COUNT   = ORBITAL_COUNT_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  start_i,
  input  logic [1:0]            operation_i,
  input  logic [7:0]            row_i,
  input  logic [7:0]            col_i,
  input  logic signed [31:0]    element_i,
  input  logic signed [7:0]     cell_a_i,
  input  logic signed [7:0]     cell_b_i,
  input  logic signed [7:0]     cell_c_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [SUM_W-1:0]      real_sum_o,
  output logic [SUM_W-1:0]      imag_sum_o,
  output logic                  saturated_o
);

  k_cfg_t cfg;

  assign pready = 1'b1;

  bpa_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  bpa_core #(
    .ORBITAL_COUNT   (ORBITAL_COUNT),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (start_i),
    .operation_i (operation_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .element_i   (element_i),
    .cell_a_i    (cell_a_i),
    .cell_b_i    (cell_b_i),
    .cell_c_i    (cell_c_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .real_sum_o  (real_sum_o),
    .imag_sum_o  (imag_sum_o),
    .saturated_o (saturated_o)
  );

endmodule

/* tb/bloch_phase_accumulator_top_test.sv */
// testbench for bloch_phase_accumulator_top: apb register, directed, saturation and random command
// transactions, each result checked against a bit-exact predictor of the k-space sums
// depends on bpa_pkg and the rtl of the block

module bloch_phase_accumulator_top_test;
  import bpa_pkg::*;

  localparam int          TAB_BITS         = TABLE_ADDR_BITS_DEF;
  localparam int          TAB_N            = 1 << TAB_BITS;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint      SUM_HI           = 64'sh0000_7fff_ffff_ffff;
  localparam longint      SUM_LO           = -SUM_HI - 64'sd1;
  localparam logic [1:0]  OP_RESERVED      = 2'd3;
  localparam logic [31:0] ELEM_MAX         = 32'h7fff_ffff;
  localparam logic [31:0] ELEM_MIN         = 32'h8000_0000;
  localparam int          CYCLE_LIMIT      = 200000;
  localparam int          SETTLE_CYCLES    = 8;
  localparam int          PHASE_ITEMS      = 180;

  typedef struct packed {
    logic [SUM_W-1:0] real_sum;
    logic [SUM_W-1:0] imag_sum;
    logic             saturated;
  } entry_sums_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  start_i;
  logic [1:0]            operation_i;
  logic [7:0]            row_i;
  logic [7:0]            col_i;
  logic signed [31:0]    element_i;
  logic signed [7:0]     cell_a_i;
  logic signed [7:0]     cell_b_i;
  logic signed [7:0]     cell_c_i;
  logic                  busy_o;
  logic                  done_o;
  logic [SUM_W-1:0]      real_sum_o;
  logic [SUM_W-1:0]      imag_sum_o;
  logic                  saturated_o;

  int          sine_rom [0:TAB_N];
  longint      re_acc [int];
  longint      im_acc [int];
  int          live_entries [$];
  entry_sums_t expected_sums [$];
  entry_sums_t head_sums;
  k_cfg_t      k_model;
  bit          start_high;
  bit          no_gaps;
  int          burst_left;
  int          items_sent;
  int          error_count;
  int          cycle_count;

  bloch_phase_accumulator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .start_i     (start_i),
    .operation_i (operation_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .element_i   (element_i),
    .cell_a_i    (cell_a_i),
    .cell_b_i    (cell_b_i),
    .cell_c_i    (cell_c_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .real_sum_o  (real_sum_o),
    .imag_sum_o  (imag_sum_o),
    .saturated_o (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic longint clip_sum(input longint acc, input longint inc,
                                      inout bit clipped);
    longint r;
    r = acc + inc;
    if (r > SUM_HI) begin
      clipped = 1'b1;
      return SUM_HI;
    end
    if (r < SUM_LO) begin
      clipped = 1'b1;
      return SUM_LO;
    end
    return r;
  endfunction

  // applies one command to the model store and returns the entry's sums after it
  function automatic entry_sums_t bloch_update(input logic [1:0] op, input logic [7:0] row,
                                               input logic [7:0] col,
                                               input logic signed [31:0] element,
                                               input logic signed [7:0] ca,
                                               input logic signed [7:0] cb,
                                               input logic signed [7:0] cc);
    entry_sums_t r;
    int          addr;
    int          ka;
    int          kb;
    int          kc;
    int          turn;
    logic [15:0] phase;
    int          idx;
    int          near_v;
    int          far_v;
    int          sin_v;
    int          cos_v;
    longint      re_v;
    longint      im_v;
    bit          clipped;
    r       = '0;
    clipped = 1'b0;
    addr    = {16'd0, row, col};
    if (row >= ORBITAL_COUNT_DEF || col >= ORBITAL_COUNT_DEF) begin
      return r;
    end
    if (op == OP_CLEAR) begin
      if (!re_acc.exists(addr)) begin
        live_entries.push_back(addr);
      end
      re_acc[addr] = 0;
      im_acc[addr] = 0;
    end else if (op == OP_ACCUM) begin
      ka     = k_model.k_a;
      kb     = k_model.k_b;
      kc     = k_model.k_c;
      turn   = ka * ca + kb * cb + kc * cc;
      phase  = turn[15:0];
      idx    = (phase >> (14 - TAB_BITS)) & (TAB_N - 1);
      near_v = sine_rom[idx];
      far_v  = sine_rom[TAB_N - idx];
      case (phase[15:14])
        2'd0: begin
          sin_v = near_v;
          cos_v = far_v;
        end
        2'd1: begin
          sin_v = far_v;
          cos_v = -near_v;
        end
        2'd2: begin
          sin_v = -near_v;
          cos_v = -far_v;
        end
        default: begin
          sin_v = -far_v;
          cos_v = near_v;
        end
      endcase
      // q9.38 product to q16.31, half rounds up
      re_acc[addr] = clip_sum(re_acc[addr], (longint'(element) * cos_v + 64) >>> 7, clipped);
      im_acc[addr] = clip_sum(im_acc[addr], (longint'(element) * sin_v + 64) >>> 7, clipped);
    end
    re_v        = re_acc[addr];
    im_v        = im_acc[addr];
    r.real_sum  = re_v[SUM_W-1:0];
    r.imag_sum  = im_v[SUM_W-1:0];
    r.saturated = clipped;
    return r;
  endfunction

  function automatic logic [31:0] random_element();
    case ($urandom_range(0, 9))
      0: return ELEM_MAX;
      1: return ELEM_MIN;
      2: return 32'($urandom_range(0, 511)) - 32'd256;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(input logic [1:0] op, input logic [7:0] row, input logic [7:0] col,
                          input logic [31:0] element, input logic [7:0] ca,
                          input logic [7:0] cb, input logic [7:0] cc);
    int gap;
    operation_i <= op;
    row_i       <= row;
    col_i       <= col;
    element_i   <= element;
    cell_a_i    <= ca;
    cell_b_i    <= cb;
    cell_c_i    <= cc;
    if (!start_high) begin
      start_i   <= 1'b1;
      start_high = 1'b1;
    end
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    expected_sums.push_back(bloch_update(op, row, col, element, ca, cb, cc));
    items_sent++;
    if (burst_left > 0 || no_gaps) begin
      burst_left--;
    end else begin
      start_i   <= 1'b0;
      start_high = 1'b0;
      gap        = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 15);
    end
  endtask

  task automatic wait_idle();
    if (start_high) begin
      start_i   <= 1'b0;
      start_high = 1'b0;
    end
    while (expected_sums.size() != 0) @(posedge clk_i);
  endtask

  // write a k register, then read it back
  task automatic write_k(input logic [1:0] sel, input logic [15:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    case (sel)
      REG_K_A: k_model.k_a = value;
      REG_K_B: k_model.k_b = value;
      REG_K_C: k_model.k_c = value;
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    if (prdata[15:0] !== value) begin
      report_mismatch($sformatf("k register %0d reads %h want %h", sel, prdata[15:0], value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_registers();
    write_k(REG_K_A, 16'hffff);
    write_k(REG_K_B, 16'hffff);
    write_k(REG_K_C, 16'hffff);
    write_k(REG_K_B, 16'($urandom));
    write_k(REG_K_A, 16'h0000);
    write_k(REG_K_B, 16'h0000);
    write_k(REG_K_C, 16'h0000);
  endtask

  task automatic test_directed();
    send_cmd(OP_CLEAR, 8'h00, 8'h00, ELEM_MAX, 8'h7f, 8'h80, 8'hff);
    send_cmd(OP_CLEAR, 8'hff, 8'hff, ELEM_MIN, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_CLEAR, 8'ha5, 8'h5a, 32'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_CLEAR, 8'h5a, 8'ha5, 32'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_READ, 8'h00, 8'h00, 32'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_RESERVED, 8'hff, 8'hff, ELEM_MAX, 8'h80, 8'h80, 8'h80);
    // k all zero: phase stays at zero whatever the cells
    send_cmd(OP_ACCUM, 8'h00, 8'h00, ELEM_MAX, 8'h7f, 8'h80, 8'h00);
    send_cmd(OP_ACCUM, 8'h00, 8'h00, ELEM_MIN, 8'h80, 8'h7f, 8'hff);
    send_cmd(OP_ACCUM, 8'hff, 8'hff, 32'd1, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_ACCUM, 8'hff, 8'hff, 32'hffff_ffff, 8'h01, 8'hff, 8'h00);
    send_cmd(OP_ACCUM, 8'hff, 8'hff, 32'd0, 8'h7f, 8'h7f, 8'h7f);
    write_k(REG_K_A, 16'hffff);
    write_k(REG_K_B, 16'h8000);
    write_k(REG_K_C, 16'h0001);
    send_cmd(OP_ACCUM, 8'ha5, 8'h5a, ELEM_MAX, 8'h7f, 8'h7f, 8'h7f);
    send_cmd(OP_ACCUM, 8'ha5, 8'h5a, ELEM_MIN, 8'h80, 8'h80, 8'h80);
    send_cmd(OP_ACCUM, 8'h5a, 8'ha5, 32'h0080_0000, 8'h01, 8'h00, 8'h00);
    send_cmd(OP_ACCUM, 8'h5a, 8'ha5, 32'h0080_0000, 8'h00, 8'h01, 8'h00);
    send_cmd(OP_ACCUM, 8'h5a, 8'ha5, 32'h0080_0000, 8'h00, 8'h00, 8'h01);
    send_cmd(OP_ACCUM, 8'h5a, 8'ha5, 32'h4000_0000, 8'hff, 8'hff, 8'hff);
    send_cmd(OP_CLEAR, 8'h00, 8'h00, 32'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_READ, 8'h00, 8'h00, 32'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_RESERVED, 8'ha5, 8'h5a, 32'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_READ, 8'h5a, 8'ha5, 32'd0, 8'h00, 8'h00, 8'h00);
  endtask

  // quarter-turn k: cells that are multiples of four give phase zero, one more gives a
  // quarter turn, so one entry clips its real sum and the other its imaginary sum
  task automatic test_saturation();
    int         j;
    logic [7:0] lat_cell;
    write_k(REG_K_A, 16'h4000);
    write_k(REG_K_B, 16'h0000);
    write_k(REG_K_C, 16'h0000);
    send_cmd(OP_CLEAR, 8'h11, 8'h22, 32'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_CLEAR, 8'hc8, 8'h03, 32'd0, 8'h00, 8'h00, 8'h00);
    for (j = 0; j < 260; j++) begin
      lat_cell = 8'($urandom_range(0, 63)) << 2;
      send_cmd(OP_ACCUM, 8'h11, 8'h22, ELEM_MAX, lat_cell, 8'($urandom), 8'($urandom));
      send_cmd(OP_ACCUM, 8'hc8, 8'h03, ELEM_MIN, lat_cell | 8'h01, 8'($urandom),
               8'($urandom));
    end
    send_cmd(OP_ACCUM, 8'h11, 8'h22, ELEM_MIN, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_ACCUM, 8'hc8, 8'h03, ELEM_MAX, 8'h01, 8'h00, 8'h00);
    send_cmd(OP_ACCUM, 8'h11, 8'h22, ELEM_MAX, 8'h02, 8'h00, 8'h00);
    send_cmd(OP_READ, 8'h11, 8'h22, 32'd0, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_RESERVED, 8'hc8, 8'h03, 32'd0, 8'h00, 8'h00, 8'h00);
  endtask

  // clear or reuse an entry, accumulate into it with the odd stray transaction, read it
  task automatic entry_sequence();
    int          addr;
    int          other;
    int          n;
    int          j;
    logic [1:0]  op;
    logic [7:0]  row;
    logic [7:0]  col;
    if (live_entries.size() == 0 || $urandom_range(0, 3) == 0) begin
      row = 8'($urandom);
      col = 8'($urandom);
      send_cmd(OP_CLEAR, row, col, $urandom, 8'($urandom), 8'($urandom), 8'($urandom));
    end else begin
      addr = live_entries[$urandom_range(0, live_entries.size() - 1)];
      row  = addr[15:8];
      col  = addr[7:0];
      if ($urandom_range(0, 2) == 0) begin
        send_cmd(OP_CLEAR, row, col, $urandom, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    n = $urandom_range(1, 12);
    for (j = 0; j < n; j++) begin
      if ($urandom_range(0, 9) == 0) begin
        other = live_entries[$urandom_range(0, live_entries.size() - 1)];
        case ($urandom_range(0, 3))
          0: op = OP_CLEAR;
          1: op = OP_READ;
          2: op = OP_RESERVED;
          default: op = OP_ACCUM;
        endcase
        send_cmd(op, other[15:8], other[7:0], random_element(), 8'($urandom), 8'($urandom),
                 8'($urandom));
      end else begin
        send_cmd(OP_ACCUM, row, col, random_element(), 8'($urandom), 8'($urandom),
                 8'($urandom));
      end
    end
    send_cmd($urandom_range(0, 1) ? OP_READ : OP_RESERVED, row, col, $urandom, 8'($urandom),
             8'($urandom), 8'($urandom));
  endtask

  task automatic test_random();
    k_cfg_t phase_k [5];
    int     p;
    int     first;
    bit     paused;
    phase_k[0] = {16'($urandom), 16'($urandom), 16'($urandom)};
    phase_k[1] = {16'hffff, 16'hffff, 16'hffff};
    phase_k[2] = {16'h0001, 16'h8000, 16'h0000};
    phase_k[3] = {16'($urandom), 16'($urandom), 16'($urandom)};
    phase_k[4] = {16'h2aaa, 16'h0400, 16'hfff0};
    paused     = 1'b0;
    for (p = 0; p < 5; p++) begin
      write_k(REG_K_A, phase_k[p].k_a);
      write_k(REG_K_B, phase_k[p].k_b);
      write_k(REG_K_C, phase_k[p].k_c);
      no_gaps = (p == 2);
      first   = items_sent;
      while (items_sent - first < PHASE_ITEMS) begin
        if (p == 1 && !paused && items_sent - first > PHASE_ITEMS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        entry_sequence();
      end
      no_gaps = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("result strobe with no command outstanding");
      end else begin
        head_sums = expected_sums.pop_front();
        if (real_sum_o !== head_sums.real_sum) begin
          report_mismatch($sformatf("real_sum %h want %h", real_sum_o, head_sums.real_sum));
        end
        if (imag_sum_o !== head_sums.imag_sum) begin
          report_mismatch($sformatf("imag_sum %h want %h", imag_sum_o, head_sums.imag_sum));
        end
        if (saturated_o !== head_sums.saturated) begin
          report_mismatch($sformatf("saturated %b want %b", saturated_o,
                                    head_sums.saturated));
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("bloch_phase_accumulator_top test failed");
    $finish;
  end

  initial begin : main
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] e;
    longint      s;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    start_i     = 1'b0;
    operation_i = OP_CLEAR;
    row_i       = '0;
    col_i       = '0;
    element_i   = '0;
    cell_a_i    = '0;
    cell_b_i    = '0;
    cell_c_i    = '0;
    k_model     = '0;
    start_high  = 1'b0;
    no_gaps     = 1'b0;
    burst_left  = 0;
    items_sent  = 0;
    error_count = 0;
    // quarter-wave sine in q1.15 from a q30 taylor series to x^17
    for (int i = 0; i <= TAB_N; i++) begin
      x    = (QUARTER_TURN_Q30 * 64'(i)) >> TAB_BITS;
      x2   = (x * x) >> 30;
      term = x;
      s    = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          s = s - longint'(term);
        end else begin
          s = s + longint'(term);
        end
      end
      if (s < 0) begin
        s = 0;
      end
      e = (64'(s) * 64'd32767 + (64'd1 << 29)) >> 30;
      sine_rom[i] = (e > 64'd32767) ? 32767 : int'(e);
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_registers();
    test_saturation();
    test_random();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_sums.size() == 0) begin
      $display("bloch_phase_accumulator_top test passed");
    end else begin
      $display("bloch_phase_accumulator_top test failed");
    end
    $finish;
  end

endmodule
